// File: hdl/hsew_pkg.sv
// Shared types for the edge-record heap sorter: controller states and the
// command and status words passed between controller and datapath.
// No dependencies.
package hsew_pkg;

    typedef enum logic [3:0]
    {
        ST_LOAD,
        ST_BUILD_INIT,
        ST_HELD_RD,
        ST_HELD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_SORT_CHK,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } hsew_state_t;

    typedef struct packed
    {
        logic load;        // take an input word into the store
        logic build_init;  // k <= (n-1)/2
        logic sort_init;   // k <= n-1
        logic k_dec;       // k <= k-1
        logic rd_held;     // read entry k as the sifted record
        logic ld_held;     // capture the sifted record
        logic rd_swap;     // read entry k and the root
        logic wr_swap;     // old root to entry k, old entry k held
        logic rd_kids;     // read both children of top
        logic wr_held;     // sift ends: held record to top
        logic wr_child;    // larger child moves up, descend
        logic emit_init;   // emit index <= 0
        logic rd_emit;     // read entry at emit index
        logic i_inc;       // advance emit index
        logic out_load;    // load the output register
        logic clear;       // end of run: empty the store
    } hsew_cmd_t;

    typedef struct packed
    {
        logic child_out;   // first child lies beyond the heap end
        logic promote;     // larger child outweighs the held record
        logic k_zero;      // loop index has reached the root
        logic emit_last;   // emit index points at the final record
    } hsew_status_t;

endpackage

// File: hdl/heap_sort_edges_by_weight_core.sv
// Top level of the edge-record heap sorter: joins controller and datapath
// and holds the output word register. Depends on hsew_pkg, hsew_ctrl,
// hsew_dpath.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------------
//  edge    | in        | edge_valid / edge_stall     | edge_weight, edge_tag, last_item
//  sorted  | out       | sorted_valid / sorted_stall | sorted_weight, sorted_tag,
//          |           |                            | run_end, dropped_flag
//
// Loading takes one input word per cycle. After the word marked last, the
// heap build and the swap phase run on a single shared sift unit, which
// handles each tree level by reading both children, then comparing and
// writing, after a set-up of its own per sift: read and capture the
// sifted record for the build, or read and swap the root for the sort.
// Each output word is read from the store by one read port and then loaded
// into the output register before the next read starts. Input is stalled
// from the last word until the final output word is in the output register.
// Reset: asynchronous, active low; clears the store count and drop flag.
// The store itself needs no clearing pass: only entries below the count
// are ever used.
// Stalls: a stalled output word is held in its register; emission waits.
module heap_sort_edges_by_weight_core
    import hsew_pkg::*;
#(
    parameter int MAX_EDGES   = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int TAG_BITS    = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          edge_valid,
    output logic                          edge_stall,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic        [TAG_BITS-1:0]    edge_tag,
    input  logic                          last_item,

    output logic                          sorted_valid,
    input  logic                          sorted_stall,
    output logic signed [WEIGHT_BITS-1:0] sorted_weight,
    output logic        [TAG_BITS-1:0]    sorted_tag,
    output logic                          run_end,
    output logic                          dropped_flag
);

    hsew_cmd_t    cmd;
    hsew_status_t status;
    logic         out_free;
    logic signed [WEIGHT_BITS-1:0] emit_weight;
    logic        [TAG_BITS-1:0]    emit_tag;
    logic                          overflow;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [WEIGHT_BITS-1:0] out_weight_reg;
    logic        [TAG_BITS-1:0]    out_tag_reg;
    logic                          out_end_reg;
    logic                          out_drop_reg;

    // the output register may take a new word when empty or being taken
    assign out_free = !out_valid_reg || !sorted_stall;

    hsew_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .last_item  (last_item),
        .out_free   (out_free),
        .status     (status),
        .edge_stall (edge_stall),
        .cmd        (cmd)
    );

    hsew_dpath #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .edge_weight (edge_weight),
        .edge_tag    (edge_tag),
        .status      (status),
        .emit_weight (emit_weight),
        .emit_tag    (emit_tag),
        .overflow    (overflow)
    );

    // hold the word until taken; drop valid once it has gone
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!sorted_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: the record just read, its run position and the drop flag
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_weight_reg <= emit_weight;
            out_tag_reg    <= emit_tag;
            out_end_reg    <= status.emit_last;
            out_drop_reg   <= overflow;
        end
    end

    assign sorted_valid  = out_valid_reg;
    assign sorted_weight = out_weight_reg;
    assign sorted_tag    = out_tag_reg;
    assign run_end       = out_end_reg;
    assign dropped_flag  = out_drop_reg;

    // a new output word never overwrites one still waiting
    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output word loaded over a stalled word");

    // no emission while the input side is open
    a_no_emit_while_loading : assert property (@(posedge clk) disable iff (!rst_n)
        !edge_stall |-> !cmd.out_load)
        else $error("output word loaded while input is accepted");

    // the final word of a run reopens the input at once
    a_reopen_after_run : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && status.emit_last) |=> !edge_stall)
        else $error("input not reopened after end of run");

endmodule

// File: hdl/hsew_dpath.sv
// Datapath of the edge-record heap sorter: record store (one write port,
// two registered read ports), sift registers, counters and compare logic.
// Depends on hsew_pkg.
module hsew_dpath
    import hsew_pkg::*;
#(
    parameter int MAX_EDGES   = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int TAG_BITS    = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsew_cmd_t                     cmd,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic        [TAG_BITS-1:0]    edge_tag,
    output hsew_status_t                  status,
    output logic signed [WEIGHT_BITS-1:0] emit_weight,
    output logic        [TAG_BITS-1:0]    emit_tag,
    output logic                          overflow
);

    localparam int IW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int RW = WEIGHT_BITS + TAG_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EDGES);

    logic [RW-1:0] store_mem [MAX_EDGES];
    logic [RW-1:0] rdata_a_reg;
    logic [RW-1:0] rdata_b_reg;
    logic [RW-1:0] held_reg;
    logic [RW-1:0] held_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          overflow_reg;
    logic          overflow_next;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] k_next;
    logic [IW-1:0] top_reg;
    logic [IW-1:0] top_next;
    logic [IW:0]   child_reg;
    logic [IW:0]   child_next;
    logic [IW-1:0] last_reg;
    logic [IW-1:0] last_next;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] i_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata;
    logic          re_a;
    logic [IW-1:0] raddr_a;
    logic          re_b;
    logic [IW-1:0] raddr_b;

    logic [CW-1:0] cnt_m1;
    logic          full;
    logic [IW-1:0] kid_b;
    logic          pick_b;
    logic [RW-1:0] picked;
    logic [IW-1:0] picked_idx;
    logic signed [WEIGHT_BITS-1:0] wa;
    logic signed [WEIGHT_BITS-1:0] wb;
    logic signed [WEIGHT_BITS-1:0] wh;
    logic signed [WEIGHT_BITS-1:0] wp;

    assign cnt_m1 = count_reg - CW'(1);
    assign full   = (count_reg == MAX_CNT);
    assign kid_b  = child_reg[IW-1:0] + IW'(1);

    assign wa = rdata_a_reg[RW-1:TAG_BITS];
    assign wb = rdata_b_reg[RW-1:TAG_BITS];
    assign wh = held_reg[RW-1:TAG_BITS];

    // pick the larger child; a right child exists only below the heap end
    assign pick_b     = (child_reg < {1'b0, last_reg}) && (wa < wb);
    assign picked     = pick_b ? rdata_b_reg : rdata_a_reg;
    assign picked_idx = pick_b ? kid_b : child_reg[IW-1:0];
    assign wp         = picked[RW-1:TAG_BITS];

    assign status.child_out = (child_reg > {1'b0, last_reg});
    assign status.promote   = (wh < wp);
    assign status.k_zero    = (k_reg == '0);
    assign status.emit_last = ((CW'(i_reg) + CW'(1)) == count_reg);

    assign emit_weight = rdata_a_reg[RW-1:TAG_BITS];
    assign emit_tag    = rdata_a_reg[TAG_BITS-1:0];
    assign overflow    = overflow_reg;

    // store port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = top_reg;
        mem_wdata = held_reg;
        if (cmd.load && !full)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[IW-1:0];
            mem_wdata = {edge_weight, edge_tag};
        end
        else if (cmd.wr_swap)
        begin
            mem_we    = 1'b1;
            mem_waddr = k_reg;
            mem_wdata = rdata_b_reg;
        end
        else if (cmd.wr_held)
        begin
            mem_we    = 1'b1;
        end
        else if (cmd.wr_child)
        begin
            mem_we    = 1'b1;
            mem_wdata = picked;
        end

        re_a    = cmd.rd_held || cmd.rd_swap || cmd.rd_kids || cmd.rd_emit;
        raddr_a = k_reg;
        if (cmd.rd_kids)
        begin
            raddr_a = child_reg[IW-1:0];
        end
        else if (cmd.rd_emit)
        begin
            raddr_a = i_reg;
        end

        re_b    = cmd.rd_swap || cmd.rd_kids;
        raddr_b = cmd.rd_kids ? kid_b : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= store_mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= store_mem[raddr_b];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        k_next        = k_reg;
        top_next      = top_reg;
        child_next    = child_reg;
        last_next     = last_reg;
        i_next        = i_reg;
        held_next     = held_reg;

        if (cmd.load)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end

        if (cmd.build_init)
        begin
            k_next = cnt_m1[IW-1:0] >> 1;
        end
        else if (cmd.sort_init)
        begin
            k_next = cnt_m1[IW-1:0];
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - IW'(1);
        end

        if (cmd.rd_held)
        begin
            top_next   = k_reg;
            child_next = {k_reg, 1'b1};
            last_next  = cnt_m1[IW-1:0];
        end
        else if (cmd.rd_swap)
        begin
            top_next   = '0;
            child_next = (IW+1)'(1);
            last_next  = k_reg - IW'(1);
        end
        else if (cmd.wr_child)
        begin
            top_next   = picked_idx;
            child_next = {picked_idx, 1'b1};
        end

        if (cmd.ld_held || cmd.wr_swap)
        begin
            held_next = rdata_a_reg;
        end

        if (cmd.emit_init)
        begin
            i_next = '0;
        end
        else if (cmd.i_inc)
        begin
            i_next = i_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            k_reg        <= '0;
            top_reg      <= '0;
            child_reg    <= '0;
            last_reg     <= '0;
            i_reg        <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            k_reg        <= k_next;
            top_reg      <= top_next;
            child_reg    <= child_next;
            last_reg     <= last_next;
            i_reg        <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: hdl/hsew_ctrl.sv
// Controller of the edge-record heap sorter: sequences load, heap build,
// root swaps, sift-down steps and the output run. Depends on hsew_pkg.
module hsew_ctrl
    import hsew_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         edge_valid,
    input  logic         last_item,
    input  logic         out_free,
    input  hsew_status_t status,
    output logic         edge_stall,
    output hsew_cmd_t    cmd
);

    hsew_state_t state_reg;
    hsew_state_t state_next;
    logic        sort_phase_reg;
    logic        sort_phase_next;
    hsew_state_t sift_end_state;

    // where a finished sift leads
    always_comb
    begin
        if (!sort_phase_reg && !status.k_zero)
        begin
            sift_end_state = ST_HELD_RD;
        end
        else
        begin
            sift_end_state = ST_SORT_CHK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sort_phase_next = sort_phase_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (edge_valid && last_item)
                begin
                    state_next = ST_BUILD_INIT;
                end
            end
            ST_BUILD_INIT:
            begin
                sort_phase_next = 1'b0;
                state_next      = ST_HELD_RD;
            end
            ST_HELD_RD:
            begin
                state_next = ST_HELD_LD;
            end
            ST_HELD_LD:
            begin
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                state_next = status.child_out ? sift_end_state : ST_SIFT_CMP;
                if (status.child_out && status.k_zero)
                begin
                    sort_phase_next = 1'b1;
                end
            end
            ST_SIFT_CMP:
            begin
                state_next = status.promote ? ST_SIFT_RD : sift_end_state;
                if (!status.promote && status.k_zero)
                begin
                    sort_phase_next = 1'b1;
                end
            end
            ST_SORT_CHK:
            begin
                state_next = status.k_zero ? ST_EMIT_RD : ST_SWAP_RD;
            end
            ST_SWAP_RD:
            begin
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR:
            begin
                state_next = ST_SIFT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        edge_stall = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                edge_stall = 1'b0;
                cmd.load   = edge_valid;
            end
            ST_BUILD_INIT:
            begin
                cmd.build_init = 1'b1;
            end
            ST_HELD_RD:
            begin
                cmd.rd_held = 1'b1;
            end
            ST_HELD_LD:
            begin
                cmd.ld_held = 1'b1;
            end
            ST_SIFT_RD:
            begin
                if (status.child_out)
                begin
                    cmd.wr_held   = 1'b1;
                    cmd.sort_init = !sort_phase_reg && status.k_zero;
                    cmd.k_dec     = sort_phase_reg || !status.k_zero;
                end
                else
                begin
                    cmd.rd_kids = 1'b1;
                end
            end
            ST_SIFT_CMP:
            begin
                if (status.promote)
                begin
                    cmd.wr_child = 1'b1;
                end
                else
                begin
                    cmd.wr_held   = 1'b1;
                    cmd.sort_init = !sort_phase_reg && status.k_zero;
                    cmd.k_dec     = sort_phase_reg || !status.k_zero;
                end
            end
            ST_SORT_CHK:
            begin
                cmd.emit_init = status.k_zero;
            end
            ST_SWAP_RD:
            begin
                cmd.rd_swap = 1'b1;
            end
            ST_SWAP_WR:
            begin
                cmd.wr_swap = 1'b1;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = out_free;
                cmd.i_inc    = out_free;
                cmd.clear    = out_free && status.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            sort_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sort_phase_reg <= sort_phase_next;
        end
    end

endmodule
